// ----- src/round_robin_scheduler_assert.svh -----
// assertion macros for the round-robin scheduler
// used by the top level only; expects clk and arst_n in scope
`ifndef ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define RRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset only
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rrs_pkg.sv -----
// shared types and constants for the round-robin scheduler
// no dependencies; used by rrs_ctrl, rrs_dp and the top level
package rrs_pkg;

	localparam int MAX_JOBS = 64;
	localparam int PTR_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	localparam int BURST_W  = 16;
	localparam int QUANT_W  = 16;
	localparam int CLOCK_W  = 22;
	localparam int SUM_W    = 28;
	localparam int JOB_W    = 6;
	localparam int COUNT_W  = 7;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(4);
	localparam logic [CLOCK_W-1:0] CLOCK_MAX     = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX       = '1;

	// operation codes carried on the slave tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// one entry of the ready ring
	typedef struct packed {
		logic [BURST_W-1:0] orig;
		logic [BURST_W-1:0] rem;
		logic [PTR_W-1:0]   job;
	} ring_entry_t;

	// result word, lowest field last
	typedef struct packed {
		logic               pad;
		logic [COUNT_W-1:0] job_count;
		logic [COUNT_W-1:0] done_count;
		logic [SUM_W-1:0]   total_turnaround;
		logic [SUM_W-1:0]   total_waiting;
		logic [CLOCK_W-1:0] turnaround_time;
		logic [CLOCK_W-1:0] waiting_time;
		logic               finished;
		logic [CLOCK_W-1:0] slice_end_time;
		logic [JOB_W-1:0]   job_index;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step_rd;
		logic ex1;
		logic ex2;
	} rrs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} rrs_stat_t;

endpackage

// ----- src/rrs_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/rrs_ctrl.sv -----
// sequencing state machine of the round-robin scheduler
// depends on rrs_pkg
module rrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              op,
	input  rrs_pkg::rrs_stat_t stat,
	output rrs_pkg::rrs_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EX1  = 2'd1;
	localparam logic [1:0] ST_EX2  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.step_rd = 1'b0;
		cmd.ex1     = 1'b0;
		cmd.ex2     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == rrs_pkg::OP_LOAD) begin
					cmd.load = 1'b1;
				end
				if (accept && op == rrs_pkg::OP_STEP) begin
					cmd.step_rd = 1'b1;
					state_d     = ST_EX1;
				end
			end
			ST_EX1: begin
				cmd.ex1 = 1'b1;
				state_d = ST_EX2;
			end
			ST_EX2: begin
				// hold until the output register can take the word
				if (stat.out_free) begin
					cmd.ex2 = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/rrs_dp.sv -----
// datapath of the round-robin scheduler: ring memory, counters, slice arithmetic
// depends on rrs_pkg and rrs_ram
module rrs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrs_pkg::rrs_cmd_t            cmd,
	output rrs_pkg::rrs_stat_t           stat,
	input  logic [rrs_pkg::BURST_W-1:0]  burst,
	input  logic                         cfg_we,
	input  logic [rrs_pkg::QUANT_W-1:0]  cfg_wdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [$bits(rrs_pkg::out_word_t)-1:0] m_tdata,
	output logic                         m_tuser
);

	localparam int EW = $bits(rrs_pkg::ring_entry_t);

	// architectural state
	logic [rrs_pkg::QUANT_W-1:0] quantum_q;
	logic [rrs_pkg::PTR_W-1:0]   head_q, tail_q;
	logic [rrs_pkg::CNT_W-1:0]   occ_q, loaded_q, fin_cnt_q;
	logic [rrs_pkg::CLOCK_W-1:0] clock_q;
	logic [rrs_pkg::SUM_W-1:0]   wsum_q, tsum_q;

	// slice stage registers
	logic [rrs_pkg::CLOCK_W-1:0] clk_nx_q;
	logic [rrs_pkg::BURST_W-1:0] rem_left_q, orig_q;
	logic [rrs_pkg::PTR_W-1:0]   job_q;
	logic                        idle_q;

	// output register
	logic                 out_valid_q;
	rrs_pkg::out_word_t   out_word_q;
	logic                 out_idle_q;

	// memory port
	logic                 ram_we;
	logic [EW-1:0]        ram_wdata, ram_rdata;
	rrs_pkg::ring_entry_t ent_rd, ent_wr;

	logic                        load_ok;
	logic [rrs_pkg::BURST_W-1:0] run;
	logic [rrs_pkg::CLOCK_W:0]   clk_sum;
	logic [rrs_pkg::CLOCK_W-1:0] clk_nx;
	logic [rrs_pkg::CLOCK_W-1:0] orig_ext, wt;
	logic [rrs_pkg::SUM_W:0]     wsum_add, tsum_add;
	logic [rrs_pkg::SUM_W-1:0]   wsum_nx, tsum_nx;
	logic                        fin;
	logic                        requeue;
	rrs_pkg::out_word_t          word_nx;

	rrs_ram #(
		.WIDTH(EW),
		.DEPTH(rrs_pkg::MAX_JOBS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.re    (cmd.step_rd),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign ent_rd  = rrs_pkg::ring_entry_t'(ram_rdata);
	assign load_ok = cmd.load && (loaded_q < rrs_pkg::CNT_W'(rrs_pkg::MAX_JOBS));

	// first slice stage: granted time and new clock
	always_comb begin
		run     = (ent_rd.rem < quantum_q) ? ent_rd.rem : quantum_q;
		clk_sum = {1'b0, clock_q}
			+ {{(rrs_pkg::CLOCK_W + 1 - rrs_pkg::BURST_W){1'b0}}, run};
		clk_nx  = (clk_sum > {1'b0, rrs_pkg::CLOCK_MAX})
			? rrs_pkg::CLOCK_MAX : clk_sum[rrs_pkg::CLOCK_W-1:0];
	end

	// second slice stage: waiting time, totals, result word
	always_comb begin
		fin      = !idle_q && (rem_left_q == '0);
		requeue  = !idle_q && !fin;
		orig_ext = {{(rrs_pkg::CLOCK_W - rrs_pkg::BURST_W){1'b0}}, orig_q};
		wt       = (clk_nx_q >= orig_ext) ? (clk_nx_q - orig_ext) : '0;
		wsum_add = {1'b0, wsum_q} + {{(rrs_pkg::SUM_W + 1 - rrs_pkg::CLOCK_W){1'b0}}, wt};
		tsum_add = {1'b0, tsum_q}
			+ {{(rrs_pkg::SUM_W + 1 - rrs_pkg::CLOCK_W){1'b0}}, clk_nx_q};
		wsum_nx  = (wsum_add > {1'b0, rrs_pkg::SUM_MAX})
			? rrs_pkg::SUM_MAX : wsum_add[rrs_pkg::SUM_W-1:0];
		tsum_nx  = (tsum_add > {1'b0, rrs_pkg::SUM_MAX})
			? rrs_pkg::SUM_MAX : tsum_add[rrs_pkg::SUM_W-1:0];

		word_nx                  = '0;
		word_nx.job_count        = rrs_pkg::COUNT_W'(loaded_q);
		if (idle_q) begin
			word_nx.slice_end_time   = clock_q;
			word_nx.total_waiting    = wsum_q;
			word_nx.total_turnaround = tsum_q;
			word_nx.done_count       = rrs_pkg::COUNT_W'(fin_cnt_q);
		end else begin
			word_nx.job_index        = rrs_pkg::JOB_W'(job_q);
			word_nx.slice_end_time   = clk_nx_q;
			word_nx.finished         = fin;
			word_nx.waiting_time     = fin ? wt : '0;
			word_nx.turnaround_time  = fin ? clk_nx_q : '0;
			word_nx.total_waiting    = fin ? wsum_nx : wsum_q;
			word_nx.total_turnaround = fin ? tsum_nx : tsum_q;
			word_nx.done_count       = rrs_pkg::COUNT_W'(fin_cnt_q + (fin ? 1'b1 : 1'b0));
		end
	end

	// write port: new job on load, unfinished job on requeue
	always_comb begin
		ram_we = load_ok || (cmd.ex2 && requeue);
		if (cmd.load) begin
			ent_wr.orig = burst;
			ent_wr.rem  = burst;
			ent_wr.job  = loaded_q[rrs_pkg::PTR_W-1:0];
		end else begin
			ent_wr.orig = orig_q;
			ent_wr.rem  = rem_left_q;
			ent_wr.job  = job_q;
		end
		ram_wdata = EW'(ent_wr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrs_pkg::QUANTUM_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			loaded_q  <= '0;
			fin_cnt_q <= '0;
			clock_q   <= '0;
			wsum_q    <= '0;
			tsum_q    <= '0;
			idle_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (load_ok) begin
				tail_q   <= (tail_q == rrs_pkg::PTR_W'(rrs_pkg::MAX_JOBS - 1))
					? '0 : tail_q + 1'b1;
				occ_q    <= occ_q + 1'b1;
				loaded_q <= loaded_q + 1'b1;
			end
			if (cmd.ex1) begin
				idle_q <= (occ_q == '0);
			end
			if (cmd.ex2 && !idle_q) begin
				clock_q <= clk_nx_q;
				head_q  <= (head_q == rrs_pkg::PTR_W'(rrs_pkg::MAX_JOBS - 1))
					? '0 : head_q + 1'b1;
				if (fin) begin
					occ_q     <= occ_q - 1'b1;
					fin_cnt_q <= fin_cnt_q + 1'b1;
					wsum_q    <= wsum_nx;
					tsum_q    <= tsum_nx;
				end else begin
					tail_q <= (tail_q == rrs_pkg::PTR_W'(rrs_pkg::MAX_JOBS - 1))
						? '0 : tail_q + 1'b1;
				end
			end
		end
	end

	// slice payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.ex1) begin
			clk_nx_q   <= clk_nx;
			rem_left_q <= ent_rd.rem - run;
			orig_q     <= ent_rd.orig;
			job_q      <= ent_rd.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ex2) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ex2) begin
			out_word_q <= word_nx;
			out_idle_q <= idle_q;
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_word_q;
	assign m_tuser       = out_idle_q;

endmodule

// ----- src/round_robin_scheduler.sv -----
// round-robin scheduler, quantum from the cfg register: a load gives no word and leaves
// the input open; a step is taken, reads the ring head from memory, then runs two arithmetic
// stages, the second of which waits while the output register is still full, and its word is
// registered there; the input stays closed from acceptance until the second stage is done
// reset: arst_n asynchronous, clears pointers, counters, clock and totals, quantum to 4;
// the ring memory is not cleared, as only entries between head and tail are ever used
module round_robin_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	// slave side
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // burst[15:0]
	input  logic          s_tuser,   // operation: 0 load, 1 step
	// master side
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,   // job_index[5:0], slice_end_time[27:6], finished[28],
	                                 // waiting_time[50:29], turnaround_time[72:51],
	                                 // total_waiting[100:73], total_turnaround[128:101],
	                                 // done_count[135:129], job_count[142:136], zero[143]
	output logic          m_tuser,   // idle: step found the ready queue empty
	// quantum register
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	`include "round_robin_scheduler_assert.svh"

	// command and status between sequencer and datapath
	rrs_pkg::rrs_cmd_t  cmd;
	rrs_pkg::rrs_stat_t stat;

	// sequencer: accepts words only when idle, walks a step through its stages
	rrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: ring memory, pointers, clock, totals and the output register
	rrs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.burst     (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// an accepted step keeps the input closed while it runs
	`RRS_ASSERT_NEXT(a_step_blocks, s_tvalid && s_tready && s_tuser == rrs_pkg::OP_STEP, !s_tready, "step did not block input")
	// finishing a step always leaves a word on the master side
	`RRS_ASSERT_NEXT(a_ex2_word, cmd.ex2, m_tvalid, "step finished without a word")
	// a word appears only from a finished step
	`RRS_ASSERT_SAME(a_word_source, $rose(m_tvalid), $past(cmd.ex2), "word without a step")

endmodule
